[sv/q15_vector_circle_limit_top_assert.svh]
// assertion macros for the vector circle limiter
`ifndef Q15_VECTOR_CIRCLE_LIMIT_TOP_ASSERT_SVH
`define Q15_VECTOR_CIRCLE_LIMIT_TOP_ASSERT_SVH
// a condition implies a consequence on the next cycle
`define VCL_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);
// a condition implies a consequence in the same cycle
`define VCL_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);
`endif

[sv/vcl_pkg.sv]
// package for the vector circle limiter: types and constants
package vcl_pkg;
  localparam int unsigned QBits = 15;
  localparam logic [14:0] Q15Max = 15'h7fff;
  localparam int unsigned RootBits = 16;
  localparam int unsigned QuotBits = 16;

  typedef struct packed {
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
  } vcl_in_t;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic [14:0] scale_factor;
  } vcl_out_t;
endpackage

[sv/vcl_sqrt.sv]
// pipelined floor square root, one result bit per stage
module vcl_sqrt
  import vcl_pkg::*;
#(
  parameter type tag_t = logic
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_rad,
  input  tag_t        in_tag,
  output logic        out_valid,
  output logic [RootBits-1:0] out_root,
  output tag_t        out_tag
);
  localparam int unsigned N = RootBits;
  logic [N:0]     vld;
  logic [31:0]    rem  [N+1];
  logic [N-1:0]   root [N+1];
  logic [31:0]    rad  [N+1];
  tag_t           tag  [N+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = in_rad;
  assign tag[0]  = in_tag;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [33:0] trial;
    logic [33:0] cur;
    always_comb begin
      cur   = {rem[i], rad[i][31:30]};
      trial = cur - {16'd0, root[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        tag[i+1] <= tag[i];
        rad[i+1] <= {rad[i][29:0], 2'b00};
        if (!trial[33]) begin
          rem[i+1]  <= trial[31:0];
          root[i+1] <= {root[i][N-2:0], 1'b1};
        end else begin
          rem[i+1]  <= cur[31:0];
          root[i+1] <= {root[i][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_tag   = tag[N];
endmodule

[sv/vcl_div.sv]
// pipelined restoring divider, one quotient bit per stage
module vcl_div
  import vcl_pkg::*;
#(
  parameter type tag_t = logic
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [29:0] in_num,
  input  logic [RootBits-1:0] in_den,
  input  tag_t        in_tag,
  output logic        out_valid,
  output logic [QuotBits-1:0] out_quot,
  output tag_t        out_tag
);
  // quotient fits 16 bits when limit <= root, which holds for an over-limit vector
  localparam int unsigned N = QuotBits;
  logic [N:0]            vld;
  logic [RootBits:0]     rem  [N+1];
  logic [29:0]           num  [N+1];
  logic [N-1:0]          quo  [N+1];
  logic [RootBits-1:0]   den  [N+1];
  tag_t                  tag  [N+1];

  assign vld[0] = in_valid;
  assign rem[0] = {3'd0, in_num[29:16]};
  assign num[0] = {in_num[15:0], 14'd0};
  assign quo[0] = '0;
  assign den[0] = in_den;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RootBits+1:0] cur;
    logic [RootBits+1:0] diff;
    always_comb begin
      cur  = {rem[i], num[i][29]};
      diff = cur - {2'b00, den[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        tag[i+1] <= tag[i];
        den[i+1] <= den[i];
        num[i+1] <= {num[i][28:0], 1'b0};
        if (!diff[RootBits+1]) begin
          rem[i+1] <= diff[RootBits:0];
          quo[i+1] <= {quo[i][N-2:0], 1'b1};
        end else begin
          rem[i+1] <= cur[RootBits:0];
          quo[i+1] <= {quo[i][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_quot  = quo[N];
  assign out_tag   = tag[N];
endmodule

[sv/q15_vector_circle_limit_top.sv]
// top level of the vector circle limiter
// Limits a Q1.15 vector to a programmed length. Fully pipelined: one transaction
// per cycle when not stalled, through the squares register, the square root (one
// bit per stage), the divide (one bit per stage), the scale multiply register and
// the output register. Stall freezes the whole pipeline; in_stall follows out_stall
// only when the output register holds a result.
module q15_vector_circle_limit_top
  import vcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  vcl_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output vcl_out_t    out_data
);
`include "q15_vector_circle_limit_top_assert.svh"

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        lim;
    logic               over;
  } tag_t;

  logic        en;
  logic [14:0] magnitude_limit;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_limit <= Q15Max;
    end else if (cfg_we) begin
      magnitude_limit <= cfg_wdata;
    end
  end

  // stage 1: squares and compare
  logic        s1_valid;
  logic [31:0] s1_sum;
  tag_t        s1_tag;
  logic [16:0] ax;
  logic [16:0] ay;
  logic [31:0] sum_next;
  logic [29:0] lim_sq;

  always_comb begin
    ax = in_data.x_in[15] ? 17'(-$signed({in_data.x_in[15], in_data.x_in}))
                          : {1'b0, in_data.x_in};
    ay = in_data.y_in[15] ? 17'(-$signed({in_data.y_in[15], in_data.y_in}))
                          : {1'b0, in_data.y_in};
    sum_next = 32'(ax * ax) + 32'(ay * ay);
    lim_sq   = magnitude_limit * magnitude_limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_sum      <= sum_next;
      s1_tag.x    <= in_data.x_in;
      s1_tag.y    <= in_data.y_in;
      s1_tag.lim  <= magnitude_limit;
      s1_tag.over <= sum_next > {2'b00, lim_sq};
    end
  end

  logic                s2_valid;
  logic [RootBits-1:0] s2_root;
  tag_t                s2_tag;

  vcl_sqrt #(.tag_t(tag_t)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s1_valid), .in_rad(s1_sum), .in_tag(s1_tag),
    .out_valid(s2_valid), .out_root(s2_root), .out_tag(s2_tag)
  );

  logic                s3_valid;
  logic [QuotBits-1:0] s3_quot;
  tag_t                s3_tag;

  vcl_div #(.tag_t(tag_t)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s2_valid), .in_num({s2_tag.lim, 15'd0}),
    .in_den(s2_root), .in_tag(s2_tag),
    .out_valid(s3_valid), .out_quot(s3_quot), .out_tag(s3_tag)
  );

  // stage: scale select and multiply
  logic [14:0] scale;
  always_comb begin
    if (!s3_tag.over || s3_quot >= {1'b0, Q15Max}) begin
      scale = Q15Max;
    end else begin
      scale = s3_quot[14:0];
    end
  end

  logic               s4_valid;
  logic signed [31:0] s4_px;
  logic signed [31:0] s4_py;
  logic [14:0]        s4_scale;
  tag_t               s4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
    if (en) begin
      s4_px    <= s3_tag.x * $signed({1'b0, scale});
      s4_py    <= s3_tag.y * $signed({1'b0, scale});
      s4_scale <= scale;
      s4_tag   <= s3_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s4_valid;
    end
    if (en) begin
      out_data.scale_factor <= s4_scale;
      if (s4_scale == Q15Max) begin
        out_data.x_out <= s4_tag.x;
        out_data.y_out <= s4_tag.y;
      end else begin
        out_data.x_out <= s4_px[30:15];
        out_data.y_out <= s4_py[30:15];
      end
    end
  end

  `VCL_ASSERT_NOW(a_stall_only_when_full, clk, rst, in_stall, out_valid && out_stall,
    "input stalled without a held result")
  `VCL_ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_data), "held result changed")
  `VCL_ASSERT_NOW(a_inside_passes, clk, rst, s3_valid && !s3_tag.over, scale == Q15Max,
    "vector inside the limit was scaled")
endmodule
